FILE: hw/rtl/efr_pkg.sv
// Shared types and constants of the escaped frame receiver.
package efr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CMD_W      = 4;
    localparam int unsigned SLOT_W     = 3;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned MAX_EMIT   = 31;

    localparam logic [BYTE_W-1:0] END_BYTE_RESET    = 8'd10;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RESET = 8'd27;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPERAND  = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_CHECKSUM = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef enum logic {
        REG_END_BYTE    = 1'b0,
        REG_ESCAPE_BYTE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] operand_count;
        logic [SLOT_W-1:0]  slot;
        logic [CMD_W-1:0]   command;
        t_kind              kind;
    } t_result;

endpackage

FILE: hw/rtl/efr_store.sv
// Frame byte store: one write port and one registered read port.
module efr_store #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/escaped_frame_receiver.sv
// Top level of the escaped frame receiver: deframing, checks and readout.
//
//  Channel   Direction  Handshake                     Content
//  s_axis    in         s_axis_tvalid/s_axis_tready   one received link byte
//  m_axis    out        m_axis_tvalid/m_axis_tready   one result item, tlast = last
//  cfg       in         i_cfg_valid/o_cfg_ready       register index and byte
//
// A data, escape or error byte is handled as it is accepted, without leaving S_RUN. A good
// frame with operands is read back from the store through the single registered read port,
// one result item per S_READ and S_LOAD pass; no byte is taken during that readout.
// Reset is synchronous; it clears the fill count, escape flag and slot and reloads the registers.
// The output register stalls the input only while it is full and not being taken.
module escaped_frame_receiver #(
    parameter int unsigned FRAME_BYTES = 32,
    parameter int unsigned SLOT_COUNT  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] kind, [5:2] command, [8:6] slot, [13:9] operand_count,
    // [21:14] data_byte, [23:22] zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(FRAME_BYTES);
    localparam int unsigned FW = $clog2(FRAME_BYTES + 1);
    localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        S_RUN,
        S_READ,
        S_LOAD
    } t_state;

    t_state                  r_state, n_state;
    logic [7:0]              r_end_byte, r_esc_byte;
    logic                    r_esc_pend, n_esc_pend;
    logic [FW-1:0]           r_fill, n_fill;
    logic [7:0]              r_hdr, n_hdr;
    logic [3:0]              r_sum, n_sum;
    logic [SW-1:0]           r_next_slot, n_next_slot;
    logic [AW-1:0]           r_rd_addr, n_rd_addr;
    logic [4:0]              r_left, n_left;
    logic [3:0]              r_cmd, n_cmd;
    logic [2:0]              r_slot, n_slot;
    logic [4:0]              r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    efr_pkg::t_result        r_out, n_out;
    logic                    r_out_last, n_out_last;

    logic                    in_acc;
    logic                    out_free;
    logic [7:0]              rx;
    logic                    wr_en;
    logic                    rd_en;
    logic [7:0]              rd_data;
    logic [FW-1:0]           op_count;
    logic [FW+4:0]           op_count_ext;
    logic [4:0]              emit;
    logic [SW+2:0]           slot_ext;

    efr_store #(
        .DEPTH  (FRAME_BYTES),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (rx),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_RUN) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;
    assign o_cfg_ready   = 1'b1;

    assign op_count     = r_fill - FW'(1);
    assign op_count_ext = {5'd0, op_count};
    assign emit         = (op_count_ext > (FW + 5)'(efr_pkg::MAX_EMIT))
                          ? 5'(efr_pkg::MAX_EMIT) : op_count_ext[4:0];
    assign slot_ext     = {3'd0, r_next_slot};

    always_comb begin
        n_state     = r_state;
        n_esc_pend  = r_esc_pend;
        n_fill      = r_fill;
        n_hdr       = r_hdr;
        n_sum       = r_sum;
        n_next_slot = r_next_slot;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_count     = r_count;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        case (r_state)
            S_RUN: begin
                if (in_acc) begin
                    if (!r_esc_pend && rx == r_esc_byte) begin
                        n_esc_pend = 1'b1;
                    end else begin
                        n_esc_pend = 1'b0;
                        if (!r_esc_pend && rx == r_end_byte) begin
                            n_fill     = '0;
                            n_sum      = '0;
                            n_out      = '0;
                            n_out_last = 1'b1;
                            if (r_fill == '0) begin
                                n_out.kind  = efr_pkg::KIND_EMPTY;
                                n_out_valid = 1'b1;
                            end else if (r_hdr[3:0] != r_sum) begin
                                n_out.kind  = efr_pkg::KIND_CHECKSUM;
                                n_out_valid = 1'b1;
                            end else begin
                                n_next_slot = (r_next_slot == SW'(SLOT_COUNT - 1))
                                              ? '0 : r_next_slot + SW'(1);
                                n_cmd   = r_hdr[7:4];
                                n_slot  = slot_ext[2:0];
                                n_count = op_count_ext[4:0];
                                if (op_count == '0) begin
                                    n_out.kind    = efr_pkg::KIND_OPERAND;
                                    n_out.command = r_hdr[7:4];
                                    n_out.slot    = slot_ext[2:0];
                                    n_out_valid   = 1'b1;
                                end else begin
                                    n_left    = emit;
                                    n_rd_addr = AW'(1);
                                    n_state   = S_READ;
                                end
                            end
                        end else if (r_fill < FW'(FRAME_BYTES)) begin
                            wr_en  = 1'b1;
                            n_fill = r_fill + FW'(1);
                            if (r_fill == '0) begin
                                n_hdr = rx;
                            end else begin
                                n_sum = r_sum + rx[3:0];
                            end
                        end else begin
                            n_out           = '0;
                            n_out.kind      = efr_pkg::KIND_OVERFLOW;
                            n_out.data_byte = rx;
                            n_out_last      = 1'b1;
                            n_out_valid     = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out.kind          = efr_pkg::KIND_OPERAND;
                    n_out.command       = r_cmd;
                    n_out.slot          = r_slot;
                    n_out.operand_count = r_count;
                    n_out.data_byte     = rd_data;
                    n_out_last          = (r_left == 5'd1);
                    n_out_valid         = 1'b1;
                    n_left              = r_left - 5'd1;
                    n_rd_addr           = r_rd_addr + AW'(1);
                    n_state             = (r_left == 5'd1) ? S_RUN : S_READ;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_end_byte  <= efr_pkg::END_BYTE_RESET;
            r_esc_byte  <= efr_pkg::ESCAPE_BYTE_RESET;
            r_esc_pend  <= 1'b0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_next_slot <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_esc_pend  <= n_esc_pend;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_next_slot <= n_next_slot;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    efr_pkg::REG_END_BYTE:    r_end_byte <= i_cfg_data;
                    efr_pkg::REG_ESCAPE_BYTE: r_esc_byte <= i_cfg_data;
                    default: begin
                        r_end_byte <= r_end_byte;
                    end
                endcase
            end
        end
        r_hdr      <= n_hdr;
        r_rd_addr  <= n_rd_addr;
        r_cmd      <= n_cmd;
        r_slot     <= n_slot;
        r_count    <= n_count;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};
    assign m_axis_tlast  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(FRAME_BYTES))
        else $error("fill count beyond frame store depth");

    a_read_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> (r_rd_addr <= AW'(FRAME_BYTES - 1)
                                && r_left != 5'd0))
        else $error("readout address or remaining count out of range");

    a_escape_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_esc_pend && rx == r_esc_byte) |=> (r_esc_pend && !m_axis_tvalid
                                                         || r_esc_pend))
        else $error("unescaped escape byte did not arm the escape flag");

endmodule
